/* rtl/crst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator package
// Shared constants, payload structs, controller states and command structs.
// ----------------------------------------------------------------------------
package crst_pkg;

  localparam int MaxSegments = 32;
  localparam int CoordBits   = 32;
  localparam int NBits       = 6;
  localparam logic [NBits-1:0] SegResetVal = 6'd8;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               final_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               run_last;
  } segment_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIV,
    ST_TSQ,
    ST_TCUBE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_OUT,
    ST_LINE
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input point and restart the segment index
    logic span_init;  // start a span: set coefficients and prev point
    logic second;     // span init selects final span (w1,w2,q,q)
    logic div_start;
    logic do_tsq;
    logic do_tcube;
    logic do_mul1;
    logic do_mul2;
    logic do_mul3;
    logic do_sum;
    logic do_out;     // load output register with curve segment
    logic do_line;    // load output register with straight segment
    logic run_last;
    logic commit;     // update the window after the item
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage : crst_pkg
`default_nettype wire

/* rtl/crst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator controller
// Sequences spans and per-segment evaluation steps for each input point.
// ----------------------------------------------------------------------------
module crst_ctrl #(
  parameter int MaxSeg = crst_pkg::MaxSegments
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire                       final_i,
  input  wire  [crst_pkg::NBits-1:0] n_cfg_i,
  input  wire  [1:0]                seen_i,
  input  crst_pkg::dp_status_t      status_i,
  output crst_pkg::dp_cmd_t         cmd_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i
);
  import crst_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [NBits-1:0] n_q, n_d, j_q, j_d;
  logic second_q, second_d, last_q, last_d;
  logic ov_q, ov_d;
  logic [NBits-1:0] n_eff;

  always_comb begin
    if (n_cfg_i == '0) n_eff = NBits'(1);
    else if (n_cfg_i > NBits'(MaxSeg)) n_eff = NBits'(MaxSeg);
    else n_eff = n_cfg_i;
  end

  wire out_free = !ov_q || out_ready_i;
  wire accept   = in_valid_i && in_ready_o;
  wire span_end = (j_q == n_q);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    j_d      = j_q;
    second_d = second_q;
    last_d   = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d = n_eff; j_d = NBits'(1); second_d = 1'b0; last_d = final_i;
          if (seen_i >= 2'd2) state_d = ST_TDIV;
          else if (seen_i == 2'd1 && final_i) state_d = ST_LINE;
        end
      end
      ST_TDIV:  if (status_i.div_done) state_d = ST_TSQ;
      ST_TSQ:   state_d = ST_TCUBE;
      ST_TCUBE: state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          if (!span_end) begin
            j_d = j_q + NBits'(1); state_d = ST_TDIV;
          end else if (last_q && !second_q) begin
            j_d = NBits'(1); second_d = 1'b1; state_d = ST_TDIV;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LINE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = accept;
        cmd_o.span_init = accept;
        cmd_o.div_start = accept;
        cmd_o.commit    = accept && !(seen_i >= 2'd2 || (seen_i == 2'd1 && final_i));
      end
      ST_TDIV:  ;
      ST_TSQ:   cmd_o.do_tsq = 1'b1;
      ST_TCUBE: cmd_o.do_tcube = 1'b1;
      ST_MUL1:  cmd_o.do_mul1 = 1'b1;
      ST_MUL2:  cmd_o.do_mul2 = 1'b1;
      ST_MUL3:  cmd_o.do_mul3 = 1'b1;
      ST_SUM:   cmd_o.do_sum = 1'b1;
      ST_OUT: begin
        cmd_o.do_out   = out_free;
        cmd_o.run_last = span_end && (second_q || !last_q);
        if (out_free) begin
          if (!span_end) cmd_o.div_start = 1'b1;
          else if (last_q && !second_q) begin
            cmd_o.span_init = 1'b1; cmd_o.second = 1'b1; cmd_o.div_start = 1'b1;
          end else cmd_o.commit = 1'b1;
        end
      end
      ST_LINE: begin
        cmd_o.do_line  = out_free;
        cmd_o.run_last = 1'b1;
        cmd_o.commit   = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (cmd_o.do_out || cmd_o.do_line) ov_d = 1'b1;
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= NBits'(1);
      j_q      <= NBits'(1);
      second_q <= 1'b0;
      last_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      j_q      <= j_d;
      second_q <= second_d;
      last_q   <= last_d;
      ov_q     <= ov_d;
    end
  end

  a_jrange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> (j_q >= NBits'(1) && j_q <= n_q)) else $error("j out of range");
  a_nolose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q) else $error("output dropped");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_out |-> out_free) else $error("overwrite of pending output");

endmodule : crst_ctrl
`default_nettype wire

/* rtl/crst_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator datapath
// Point window, t divider, shared per-axis multipliers and output register.
// ----------------------------------------------------------------------------
module crst_datapath #(
  parameter int MaxSeg = crst_pkg::MaxSegments
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  crst_pkg::point_t           point_i,
  input  wire  [crst_pkg::NBits-1:0] n_cfg_i,
  input  crst_pkg::dp_cmd_t          cmd_i,
  output crst_pkg::dp_status_t       status_o,
  output logic [1:0]                 seen_o,
  output crst_pkg::segment_t         seg_o
);
  import crst_pkg::*;

  localparam int PW = 32;        // port coordinate width
  localparam int CW = PW + 4;    // coefficient width
  localparam int SW = PW + 24;   // sum width

  logic signed [PW-1:0] w_q [3][3]; // [slot][axis]
  logic [1:0] seen_q;
  logic signed [PW-1:0] q_q [3];
  logic fin_q;
  logic signed [PW-1:0] prev_q [3];
  logic signed [CW-1:0] c1_q [3], c2_q [3], c3_q [3], p1x2_q [3];
  logic signed [SW-1:0] acc_q [3];
  logic [NBits-1:0] n_q, jcnt_q;
  logic [16:0] t_q, t2_q, t3_q;
  logic [33:0] t2w;
  logic [33:0] t3w;
  segment_t seg_q;

  // Divider for t = (j*65536 + n/2)/n, truncated; restoring, one bit per cycle.
  logic [22:0] rem_q;
  logic [22:0] num_q;
  logic [16:0] quo_q;
  logic [4:0]  dcnt_q;
  logic        dbusy_q;
  logic [NBits-1:0] n_eff;
  logic [23:0] rem_sh;

  logic signed [PW-1:0] a0 [3], a1 [3], a2 [3], a3 [3];
  logic signed [CW-1:0] mul_c [3];
  logic [16:0] mul_t;

  function automatic logic [NBits-1:0] jcnt_q_next(input dp_cmd_t c,
                                                   input logic [NBits-1:0] j);
    return (c.load || c.span_init) ? NBits'(1) : j + NBits'(1);
  endfunction

  function automatic logic q_fin(input dp_cmd_t c, input point_t p, input logic f);
    return c.load ? p.final_point : f;
  endfunction

  function automatic logic signed [PW-1:0] pin(input point_t p, input int a);
    logic signed [PW-1:0] r;
    r = p.point_x;
    if (a == 1) r = p.point_y;
    if (a == 2) r = p.point_z;
    return r;
  endfunction

  function automatic logic signed [PW-1:0] sat_fn(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo, s;
    hi = SW'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
    lo = -hi - SW'(1);
    s  = v;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[PW-1:0];
  endfunction

  always_comb begin
    if (n_cfg_i == '0) n_eff = NBits'(1);
    else if (n_cfg_i > NBits'(MaxSeg)) n_eff = NBits'(MaxSeg);
    else n_eff = n_cfg_i;
  end

  assign rem_sh = {rem_q, num_q[22]};
  assign status_o.div_done = !dbusy_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.second) begin
        a0[a] = w_q[1][a]; a1[a] = w_q[2][a]; a2[a] = q_q[a]; a3[a] = q_q[a];
      end else begin
        a0[a] = (seen_q >= 2'd3) ? w_q[0][a] : w_q[1][a];
        a1[a] = w_q[1][a]; a2[a] = w_q[2][a]; a3[a] = q_q[a];
      end
      if (cmd_i.load) begin
        // span_init with load uses the incoming point as q
        a3[a] = point_i.point_x;
        if (a == 1) a3[a] = point_i.point_y;
        if (a == 2) a3[a] = point_i.point_z;
      end
    end
  end

  always_comb begin
    mul_t = t_q;
    if (cmd_i.do_mul2) mul_t = t2_q;
    if (cmd_i.do_mul3) mul_t = t3_q;
    for (int a = 0; a < 3; a++) begin
      mul_c[a] = c1_q[a];
      if (cmd_i.do_mul2) mul_c[a] = c2_q[a];
      if (cmd_i.do_mul3) mul_c[a] = c3_q[a];
    end
  end

  assign t2w = {17'd0, t_q} * {17'd0, t_q} + 34'd32768;
  assign t3w = {17'd0, t2_q} * {17'd0, t_q} + 34'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 2'd0;
      dbusy_q <= 1'b0;
      dcnt_q  <= 5'd0;
      rem_q   <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      n_q     <= NBits'(1);
      jcnt_q  <= NBits'(1);
      for (int s = 0; s < 3; s++)
        for (int a = 0; a < 3; a++) w_q[s][a] <= '0;
    end else begin
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 5'd23;
        rem_q   <= '0;
        quo_q   <= '0;
        num_q   <= (23'(jcnt_q_next(cmd_i, jcnt_q)) << 16)
                   + 23'((cmd_i.load ? n_eff : n_q) >> 1);
        if (cmd_i.load) n_q <= n_eff;
        jcnt_q <= jcnt_q_next(cmd_i, jcnt_q);
      end else if (dbusy_q) begin
        num_q <= num_q << 1;
        if (rem_sh >= 24'(n_q)) begin
          rem_q <= 23'(rem_sh - 24'(n_q));
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_sh[22:0];
          quo_q <= {quo_q[15:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
        if (dcnt_q == 5'd1) dbusy_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (q_fin(cmd_i, point_i, fin_q)) begin
          seen_q <= 2'd0;
          for (int s = 0; s < 3; s++)
            for (int a = 0; a < 3; a++) w_q[s][a] <= '0;
        end else begin
          for (int a = 0; a < 3; a++) begin
            w_q[0][a] <= w_q[1][a];
            w_q[1][a] <= w_q[2][a];
            w_q[2][a] <= cmd_i.load ? pin(point_i, a) : q_q[a];
          end
          if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fin_q <= point_i.final_point;
      for (int a = 0; a < 3; a++) q_q[a] <= pin(point_i, a);
    end
    if (cmd_i.span_init) begin
      for (int a = 0; a < 3; a++) begin
        c1_q[a] <= CW'(a2[a]) - CW'(a0[a]);
        c2_q[a] <= (CW'(a0[a]) <<< 1) - CW'(a1[a]) * CW'(5) + (CW'(a2[a]) <<< 2)
                   - CW'(a3[a]);
        c3_q[a] <= CW'(a1[a]) * CW'(3) - CW'(a0[a]) - CW'(a2[a]) * CW'(3) + CW'(a3[a]);
        p1x2_q[a] <= CW'(a1[a]) <<< 1;
        prev_q[a] <= a1[a];
      end
    end
    if (status_o.div_done) t_q <= quo_q;
    if (cmd_i.do_tsq)   t2_q <= t2w[32:16];
    if (cmd_i.do_tcube) t3_q <= t3w[32:16];
    if (cmd_i.do_mul1) begin
      for (int a = 0; a < 3; a++)
        acc_q[a] <= (SW'(p1x2_q[a]) <<< 16) + SW'(mul_c[a]) * SW'($signed({1'b0, mul_t}));
    end
    if (cmd_i.do_mul2 || cmd_i.do_mul3) begin
      for (int a = 0; a < 3; a++)
        acc_q[a] <= acc_q[a] + SW'(mul_c[a]) * SW'($signed({1'b0, mul_t}));
    end
    if (cmd_i.do_sum) begin
      for (int a = 0; a < 3; a++)
        acc_q[a] <= (acc_q[a] + SW'(65536)) >>> 17;
    end
    if (cmd_i.do_out) begin
      seg_q.start_x <= prev_q[0]; seg_q.start_y <= prev_q[1]; seg_q.start_z <= prev_q[2];
      seg_q.end_x <= sat_fn(acc_q[0]);
      seg_q.end_y <= sat_fn(acc_q[1]);
      seg_q.end_z <= sat_fn(acc_q[2]);
      seg_q.run_last <= cmd_i.run_last;
      // A new span loads its own start point instead.
      for (int a = 0; a < 3; a++)
        if (!cmd_i.span_init) prev_q[a] <= sat_fn(acc_q[a]);
    end
    if (cmd_i.do_line) begin
      seg_q.start_x <= w_q[2][0]; seg_q.start_y <= w_q[2][1]; seg_q.start_z <= w_q[2][2];
      seg_q.end_x <= q_q[0]; seg_q.end_y <= q_q[1]; seg_q.end_z <= q_q[2];
      seg_q.run_last <= 1'b1;
    end
  end

  assign seen_o = seen_q;
  assign seg_o  = seg_q;

  a_t_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_tsq |-> t_q <= 17'd65536) else $error("t above one");
  a_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && cmd_i.load && point_i.final_point |=> seen_q == 2'd0)
    else $error("window not cleared");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dbusy_q) else $error("divider did not start");

endmodule : crst_datapath
`default_nettype wire

/* rtl/catmull_rom_spline_tessellator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// From an accepted point to its first segment the controller steps through
// the t divider, then t^2, t^3, three multiply-accumulates, rounding, output.
// A new point is taken only once all segments of the last one have gone into
// the output register, so output stalls also hold off the next point.
// Reset (rst_ni low, asynchronous) clears the window, point count and
// handshake state and sets segments_per_span to 8.
// ----------------------------------------------------------------------------
// Catmull-Rom spline tessellator top level
// Turns a stream of control points into line segments along the spline.
// ----------------------------------------------------------------------------
module catmull_rom_spline_tessellator_top #(
  parameter int MAX_SEGMENTS = crst_pkg::MaxSegments
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  crst_pkg::point_t           in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output crst_pkg::segment_t         out_data_o,
  input  wire                        cfg_we_i,
  input  wire  [crst_pkg::NBits-1:0] cfg_wdata_i
);
  import crst_pkg::*;

  // User must write the segment count register only while idle; unchecked.
  logic [NBits-1:0] seg_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seg_cnt_q <= SegResetVal;
    else if (cfg_we_i) seg_cnt_q <= cfg_wdata_i;
  end

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [1:0] seen;

  // The controller steps through each span, one segment at a time.
  crst_ctrl #(.MaxSeg(MAX_SEGMENTS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .final_i     (in_data_i.final_point),
    .n_cfg_i     (seg_cnt_q),
    .seen_i      (seen),
    .status_i    (status),
    .cmd_o       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  // The datapath holds the window and evaluates curve points.
  crst_datapath #(.MaxSeg(MAX_SEGMENTS)) u_dp (
    .clk_i, .rst_ni,
    .point_i (in_data_i),
    .n_cfg_i (seg_cnt_q),
    .cmd_i   (cmd),
    .status_o(status),
    .seen_o  (seen),
    .seg_o   (out_data_o)
  );

endmodule : catmull_rom_spline_tessellator_top
`default_nettype wire

/* tb/sv/crst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator checker
// Watches the point and segment channels, predicts the segments each accepted
// point should produce and compares every accepted segment field by field.
// ----------------------------------------------------------------------------
module crst_checker (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire                        in_ready_i,
  input  crst_pkg::point_t           in_data_i,
  input  wire                        out_valid_i,
  input  wire                        out_ready_i,
  input  crst_pkg::segment_t         out_data_i,
  input  wire                        cfg_we_i,
  input  wire  [crst_pkg::NBits-1:0] cfg_wdata_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         segs_seen_o
);
  import crst_pkg::*;

  logic [NBits-1:0]   seg_count;
  logic signed [63:0] win [3][3];
  int                 held;
  segment_t           seg_queue[$];

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (CoordBits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Halving with rounding half up; >>> on signed values is a floor shift.
  function automatic logic signed [63:0] axis_point(
      input logic signed [63:0] p0, p1, p2, p3, t, t2, t3);
    logic signed [63:0] s;
    s = 2 * p1 * 65536 + (p2 - p0) * t + (2 * p0 - 5 * p1 + 4 * p2 - p3) * t2 +
        (-p0 + 3 * p1 - 3 * p2 + p3) * t3;
    return clamp((s + 65536) >>> 17);
  endfunction

  task automatic push_seg(input logic signed [63:0] a [3], input logic signed [63:0] b [3]);
    segment_t s;
    s.start_x = a[0][31:0]; s.start_y = a[1][31:0]; s.start_z = a[2][31:0];
    s.end_x   = b[0][31:0]; s.end_y   = b[1][31:0]; s.end_z   = b[2][31:0];
    s.run_last = 1'b0;
    seg_queue.push_back(s);
  endtask

  task automatic predict_span(input logic signed [63:0] p0 [3], p1 [3], p2 [3], p3 [3],
                              input int n);
    logic signed [63:0] prev [3];
    logic signed [63:0] cur [3];
    logic [63:0]        t, t2, t3;
    prev = p1;
    for (int j = 1; j <= n; j++) begin
      t  = (j * 64'd65536 + n / 2) / n;
      t2 = (t * t + 64'd32768) >> 16;
      t3 = (t2 * t + 64'd32768) >> 16;
      for (int i = 0; i < 3; i++) begin
        cur[i] = axis_point(p0[i], p1[i], p2[i], p3[i], $signed(t), $signed(t2),
                            $signed(t3));
      end
      push_seg(prev, cur);
      prev = cur;
    end
  endtask

  task automatic predict_point(input point_t p);
    logic signed [63:0] q [3];
    logic signed [63:0] w0 [3];
    logic signed [63:0] w1 [3];
    logic signed [63:0] w2 [3];
    int n, queued;
    n = (seg_count == 0) ? 1 : (seg_count > MaxSegments ? MaxSegments : seg_count);
    q[0] = p.point_x; q[1] = p.point_y; q[2] = p.point_z;
    w0 = win[0]; w1 = win[1]; w2 = win[2];
    // With only two points held, the older one stands in for the missing one.
    if (held < 3) w0 = w1;
    queued = seg_queue.size();
    if (held == 1) begin
      if (p.final_point) push_seg(w2, q);
    end else if (held >= 2) begin
      predict_span(w0, w1, w2, q, n);
      if (p.final_point) predict_span(w1, w2, q, q, n);
    end
    if (seg_queue.size() > queued) seg_queue[$].run_last = 1'b1;
    if (p.final_point) begin
      held = 0;
      for (int k = 0; k < 3; k++) win[k] = '{0, 0, 0};
    end else begin
      win[0] = win[1]; win[1] = win[2]; win[2] = q;
      if (held < 3) held++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t e;
    if (!rst_ni) begin
      seg_count   <= SegResetVal;
      held        = 0;
      for (int k = 0; k < 3; k++) win[k] = '{0, 0, 0};
      seg_queue.delete();
      errors_o    = 0;
      segs_seen_o = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        segs_seen_o++;
        if (seg_queue.size() == 0) begin
          report_mismatch("unexpected segment", out_data_i.start_x, 0);
        end else begin
          e = seg_queue.pop_front();
          if (out_data_i.start_x !== e.start_x) report_mismatch("start_x", out_data_i.start_x, e.start_x);
          if (out_data_i.start_y !== e.start_y) report_mismatch("start_y", out_data_i.start_y, e.start_y);
          if (out_data_i.start_z !== e.start_z) report_mismatch("start_z", out_data_i.start_z, e.start_z);
          if (out_data_i.end_x !== e.end_x) report_mismatch("end_x", out_data_i.end_x, e.end_x);
          if (out_data_i.end_y !== e.end_y) report_mismatch("end_y", out_data_i.end_y, e.end_y);
          if (out_data_i.end_z !== e.end_z) report_mismatch("end_z", out_data_i.end_z, e.end_z);
          if (out_data_i.run_last !== e.run_last)
            report_mismatch("run_last", out_data_i.run_last, e.run_last);
        end
      end
      if (in_valid_i && in_ready_i) predict_point(in_data_i);
      if (cfg_we_i) seg_count <= cfg_wdata_i;
      pending_o = seg_queue.size();
    end
  end

  // A prediction left over at the end is counted by the top through pending_o.
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator testbench
// Drives control-point curves under several segment counts with random gaps
// and back-pressure; a separate checker predicts and compares every segment.
// ----------------------------------------------------------------------------
module tb;
  import crst_pkg::*;

  localparam int WatchLimit = 200000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  point_t           in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  segment_t         out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [NBits-1:0] cfg_wdata_i = '0;
  int               errors, pending, segs_seen;
  int               points_sent = 0;
  int               idle_cycles = 0;
  bit               long_hold = 1'b0;   // receiver holds off while set
  bit               sink_free = 1'b0;   // no random stalls on the receiver
  bit               src_free = 1'b0;    // no random gaps on the sender

  always #6 clk_i = ~clk_i;

  catmull_rom_spline_tessellator_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  crst_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending), .segs_seen_o(segs_seen)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  always begin
    int g;
    @(negedge clk_i);
    if (long_hold) begin
      out_ready_i <= 1'b0;
    end else if (sink_free) begin
      out_ready_i <= 1'b1;
    end else begin
      g = gap_len();
      if (g == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Watchdog expired with %0d segments outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One transfer on the point channel; valid stays up until accepted. The
  // next call or drain() takes valid down or replaces the payload at the
  // following falling edge.
  task automatic send_point(input logic [31:0] x, y, z, input bit fin);
    int g;
    g = src_free ? 0 : gap_len();
    @(negedge clk_i);
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_data_i  <= '{point_x: x, point_y: y, point_z: z, final_point: fin};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
  endtask

  // Wait until every predicted segment has come, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_segments(input logic [NBits-1:0] n);
    drain();
    cfg_wdata_i <= n;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 5) return $urandom();
    return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
  endfunction

  task automatic rand_curve(input int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  initial begin
    int len, r;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: lone final point emits nothing, two points give one straight
    // segment, then a full curve under the reset segment count.
    send_point(32'h00010000, 32'h0, 32'h0, 1'b1);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'hffffffff, 32'h7fffffff, 32'h80000000, 1'b1);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    send_point(32'h00010000, 32'h00020000, 32'hfffd0000, 1'b0);
    send_point(32'h00050000, 32'hfffc0000, 32'h00010000, 1'b0);
    send_point(32'h00020000, 32'h0, 32'h00030000, 1'b1);

    // Saturation: alternating extremes overshoot the coordinate range.
    set_segments(6'd1);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);

    // Out-of-range counts: zero acts as one, above the maximum clamps.
    set_segments(6'd0);
    rand_curve(3);
    set_segments(6'd63);
    rand_curve(3);
    set_segments(6'd32);
    rand_curve(4);

    // Back-pressure: receiver holds off while the sender keeps offering.
    set_segments(6'd3);
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(negedge clk_i);
        long_hold = 1'b0;
      end
      begin
        src_free = 1'b1;
        rand_curve(6);
        src_free = 1'b0;
      end
    join
    drain();

    // Random part: mostly small segment counts, mostly well-formed curves.
    while (points_sent < 320) begin
      r = $urandom_range(0, 19);
      if (r == 0) set_segments(6'd32);
      else if (r < 4) set_segments($urandom_range(1, 6));
      else if (r == 4) set_segments($urandom_range(0, 63));
      sink_free = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      rand_curve(len);
    end
    sink_free = 1'b0;

    drain();
    repeat (100) @(negedge clk_i);
    $display("Sent %0d control points and checked %0d segments", points_sent, segs_seen);
    $display("Counts covered 0, 1, 3, 8, 32, 63 and random values, with stalls");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
